// File: src/jpep_pkg.sv
// ----------------------------------------------------------------------------
// Joystick press-event pacer package
// Shared types, register indexes, reset values and direction codes.
// ----------------------------------------------------------------------------
package jpep_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [2:0] {
    DIR_NONE   = 3'd0,
    DIR_UP     = 3'd1,
    DIR_DOWN   = 3'd2,
    DIR_LEFT   = 3'd3,
    DIR_RIGHT  = 3'd4,
    DIR_CENTER = 3'd5
  } dir_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REPEAT_DELAY = 2'd0,
    REG_REPEAT_RATE  = 2'd1,
    REG_REBOOT_HOLD  = 2'd2
  } reg_idx_e;

  localparam logic [CfgW-1:0] RepeatDelayReset = 16'd400;
  localparam logic [CfgW-1:0] RepeatRateReset  = 16'd120;
  localparam logic [CfgW-1:0] RebootHoldReset  = 16'd10000;

  typedef struct packed {
    logic [CfgW-1:0] repeat_delay;
    logic [CfgW-1:0] repeat_rate;
    logic [CfgW-1:0] reboot_hold;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       direction;
    logic [TimeW-1:0] now_ms;
    logic             display_busy;
  } sample_t;

  typedef struct packed {
    dir_e             prev_dir;
    dir_e             pending;
    logic [TimeW-1:0] hold_start;
    logic [TimeW-1:0] last_emit;
    logic [TimeW-1:0] center_start;
  } state_t;

  typedef struct packed {
    logic event_valid;
    dir_e event_code;
    logic reboot_request;
  } result_t;

  localparam state_t StateReset = '{
    prev_dir:     DIR_NONE,
    pending:      DIR_NONE,
    hold_start:   '0,
    last_emit:    '0,
    center_start: '0
  };

endpackage

// File: src/jpep_cfg_regs.sv
// ----------------------------------------------------------------------------
// Joystick press-event pacer configuration registers
// Holds the repeat delay, repeat rate and reboot hold times.
// ----------------------------------------------------------------------------
module jpep_cfg_regs
  import jpep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_REPEAT_DELAY: cfg_d.repeat_delay = cfg_data_i;
        REG_REPEAT_RATE:  cfg_d.repeat_rate  = cfg_data_i;
        REG_REBOOT_HOLD:  cfg_d.reboot_hold  = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{repeat_delay: RepeatDelayReset,
                 repeat_rate:  RepeatRateReset,
                 reboot_hold:  RebootHoldReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/jpep_step.sv
// ----------------------------------------------------------------------------
// Joystick press-event pacer step logic
// Computes the next pacer state and the result for one sample.
// ----------------------------------------------------------------------------
module jpep_step
  import jpep_pkg::*;
(
  input  sample_t sample_i,
  input  state_t  state_i,
  input  cfg_t    cfg_i,
  output state_t  state_o,
  output result_t result_o
);

  dir_e             dir;
  logic [TimeW-1:0] now;
  logic [TimeW-1:0] center_elapsed;
  logic [TimeW-1:0] hold_elapsed;
  logic [TimeW-1:0] emit_elapsed;
  logic             reboot;
  logic             repeat_due;
  logic             is_edge;
  state_t           nxt;

  assign now            = sample_i.now_ms;
  assign center_elapsed = now - state_i.center_start;
  assign hold_elapsed   = now - state_i.hold_start;
  assign emit_elapsed   = now - state_i.last_emit;

  always_comb begin
    if (sample_i.direction > 3'(DIR_CENTER)) begin
      dir = DIR_NONE;
    end else begin
      dir = dir_e'(sample_i.direction);
    end
  end

  assign is_edge    = (state_i.prev_dir != dir);
  assign reboot     = (dir == DIR_CENTER) && (state_i.center_start != '0) &&
                      (center_elapsed >= {{(TimeW-CfgW){1'b0}}, cfg_i.reboot_hold});
  assign repeat_due = (hold_elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.repeat_delay}) &&
                      (emit_elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.repeat_rate});

  always_comb begin
    nxt = state_i;
    if (dir == DIR_CENTER) begin
      if (state_i.center_start == '0) begin
        nxt.center_start = now;
      end
    end else begin
      nxt.center_start = '0;
    end
    case (dir)
      DIR_UP, DIR_DOWN: begin
        if (is_edge) begin
          nxt.hold_start = now;
          nxt.pending    = dir;
        end else if (repeat_due) begin
          nxt.pending = dir;
        end
      end
      DIR_LEFT, DIR_RIGHT, DIR_CENTER: begin
        if (is_edge) begin
          nxt.pending = dir;
        end
      end
      default: begin
      end
    endcase
    nxt.prev_dir = dir;
  end

  always_comb begin
    state_o  = nxt;
    result_o = '{event_valid: 1'b0, event_code: DIR_NONE, reboot_request: 1'b0};
    if (reboot) begin
      state_o                 = StateReset;
      result_o.reboot_request = 1'b1;
    end else if ((nxt.pending != DIR_NONE) && !sample_i.display_busy) begin
      result_o.event_valid = 1'b1;
      result_o.event_code  = nxt.pending;
      state_o.last_emit    = now;
      state_o.pending      = DIR_NONE;
    end
  end

endmodule

// File: src/joystick_press_event_pacer.sv
// An accepted sample word is held in the input register, then in the result register.
// Throughput: one sample per cycle unless stalled; the state is one registered pass.
// Reset: asynchronous, active low; clears the pacer state and the pipeline valid flags,
// and loads the default repeat delay, repeat rate and reboot hold times.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
// Joystick press-event pacer
// Edge detection, up/down auto-repeat, display-busy holdback and a long
// center-hold reboot request, one poll sample per word.
// ----------------------------------------------------------------------------
module joystick_press_event_pacer
  import jpep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         direction_i,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic               display_busy_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               event_valid_o,
  output logic [2:0]         event_code_o,
  output logic               reboot_request_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cfg_t    cfg;
  sample_t in_q;
  logic    in_valid_q;
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    res_valid_q;
  logic    out_free;
  logic    in_load;
  logic    advance;

  jpep_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  jpep_step u_step (
    .sample_i (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign out_free   = !res_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_free) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= '{direction: direction_i, now_ms: now_ms_i, display_busy: display_busy_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign event_valid_o    = res_q.event_valid;
  assign event_code_o     = 3'(res_q.event_code);
  assign reboot_request_o = res_q.reboot_request;

endmodule

// File: verif/press_event_checker.sv
// ----------------------------------------------------------------------------
// Press event checker
// Watches the sample, result and register channels of the joystick pacer,
// predicts one result word per accepted sample word and compares the
// results field by field in order.
// ----------------------------------------------------------------------------
module press_event_checker
  import jpep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         direction_i,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic               display_busy_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               event_valid_i,
  input  logic [2:0]         event_code_i,
  input  logic               reboot_request_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 mismatches_o,
  output int                 words_in_flight_o
);

  cfg_t    pacer_cfg;
  state_t  pacer_state;
  result_t expected_events[$];
  result_t oldest_event;
  int      mismatches;

  function automatic result_t pace_sample(input logic [2:0] raw_dir,
                                          input logic [TimeW-1:0] now,
                                          input logic busy);
    dir_e             dir;
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] since_emit;
    logic [TimeW-1:0] center_held;
    result_t          res;
    res = '{event_valid: 1'b0, event_code: DIR_NONE, reboot_request: 1'b0};
    dir = (raw_dir > DIR_CENTER) ? DIR_NONE : dir_e'(raw_dir);
    held = now - pacer_state.hold_start;
    since_emit = now - pacer_state.last_emit;
    center_held = now - pacer_state.center_start;

    // A center start of zero means no hold is being timed.
    if (dir == DIR_CENTER) begin
      if (pacer_state.center_start == '0) begin
        pacer_state.center_start = now;
      end else if (center_held >= pacer_cfg.reboot_hold) begin
        pacer_state = StateReset;
        res.reboot_request = 1'b1;
        return res;
      end
    end else begin
      pacer_state.center_start = '0;
    end

    if (dir == DIR_UP || dir == DIR_DOWN) begin
      if (pacer_state.prev_dir != dir) begin
        pacer_state.hold_start = now;
        pacer_state.pending = dir;
      end else if (held > pacer_cfg.repeat_delay && since_emit > pacer_cfg.repeat_rate) begin
        pacer_state.pending = dir;
      end
    end else if (dir != DIR_NONE && pacer_state.prev_dir != dir) begin
      pacer_state.pending = dir;
    end
    pacer_state.prev_dir = dir;

    if (pacer_state.pending != DIR_NONE && !busy) begin
      res.event_valid = 1'b1;
      res.event_code = pacer_state.pending;
      pacer_state.last_emit = now;
      pacer_state.pending = DIR_NONE;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pacer_cfg = '{repeat_delay: RepeatDelayReset, repeat_rate: RepeatRateReset,
                    reboot_hold: RebootHoldReset};
      pacer_state = StateReset;
      expected_events.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $error("result word accepted with no result expected");
          mismatches++;
        end else begin
          oldest_event = expected_events.pop_front();
          if (event_valid_i !== oldest_event.event_valid) begin
            $error("event_valid: expected %0d, actual %0d",
                   oldest_event.event_valid, event_valid_i);
            mismatches++;
          end
          if (event_code_i !== oldest_event.event_code) begin
            $error("event_code: expected %0d, actual %0d",
                   oldest_event.event_code, event_code_i);
            mismatches++;
          end
          if (reboot_request_i !== oldest_event.reboot_request) begin
            $error("reboot_request: expected %0d, actual %0d",
                   oldest_event.reboot_request, reboot_request_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_events.push_back(pace_sample(direction_i, now_ms_i, display_busy_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_REPEAT_DELAY: pacer_cfg.repeat_delay = cfg_data_i;
          REG_REPEAT_RATE:  pacer_cfg.repeat_rate = cfg_data_i;
          REG_REBOOT_HOLD:  pacer_cfg.reboot_hold = cfg_data_i;
          default: ;
        endcase
      end
    end
    mismatches_o <= mismatches;
    words_in_flight_o <= expected_events.size();
  end

endmodule

// File: verif/tb_joystick_press_event_pacer.sv
// ----------------------------------------------------------------------------
// Joystick press-event pacer testbench
// Drives directed and random poll samples through the pacer under several
// register settings, with random idling on both channels, while a checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_joystick_press_event_pacer;
  import jpep_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int Latency = 1;
  localparam int SamplesPerPhase = 475;
  localparam logic [2:0] DirInvalidLo = 3'd6;
  localparam logic [2:0] DirInvalidHi = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         direction_i;
  logic [TimeW-1:0]   now_ms_i;
  logic               display_busy_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               event_valid_o;
  logic [2:0]         event_code_o;
  logic               reboot_request_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;

  int               mismatches;
  int               words_in_flight;
  int               idle_cycles = 0;
  int               samples_sent = 0;
  logic             steady;
  logic [TimeW-1:0] clock_ms;
  cfg_t             active_cfg;

  joystick_press_event_pacer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .direction_i      (direction_i),
    .now_ms_i         (now_ms_i),
    .display_busy_i   (display_busy_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_valid_o    (event_valid_o),
    .event_code_o     (event_code_o),
    .reboot_request_o (reboot_request_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  press_event_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .direction_i       (direction_i),
    .now_ms_i          (now_ms_i),
    .display_busy_i    (display_busy_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_valid_i     (event_valid_o),
    .event_code_i      (event_code_o),
    .reboot_request_i  (reboot_request_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .mismatches_o      (mismatches),
    .words_in_flight_o (words_in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 19);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [2:0] dir, input logic [TimeW-1:0] now,
                             input logic busy);
    if (!steady) begin
      while ($urandom_range(99) < 19) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    direction_i <= dir;
    now_ms_i <= now;
    display_busy_i <= busy;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_pacer;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_in_flight != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic put_register(input reg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_config(input logic [CfgW-1:0] delay, input logic [CfgW-1:0] rate,
                             input logic [CfgW-1:0] hold);
    put_register(REG_REPEAT_DELAY, delay);
    put_register(REG_REPEAT_RATE, rate);
    put_register(REG_REBOOT_HOLD, hold);
    cfg_valid_i <= 1'b0;
    active_cfg = '{repeat_delay: delay, repeat_rate: rate, reboot_hold: hold};
  endtask

  // One stretch of a single joystick level, with time steps scaled so that
  // repeats and long center holds are actually reached.
  task automatic play_hold;
    logic [2:0] dir;
    int         pick;
    int         run_len;
    int         step_max;
    pick = $urandom_range(99);
    run_len = $urandom_range(1, 10);
    if (pick < 30) begin
      dir = DIR_UP;
    end else if (pick < 55) begin
      dir = DIR_DOWN;
    end else if (pick < 70) begin
      dir = DIR_CENTER;
    end else if (pick < 78) begin
      dir = DIR_LEFT;
    end else if (pick < 86) begin
      dir = DIR_RIGHT;
    end else if (pick < 96) begin
      dir = DIR_NONE;
    end else begin
      dir = (pick < 98) ? DirInvalidLo : DirInvalidHi;
    end
    if (dir == DIR_UP || dir == DIR_DOWN) begin
      step_max = (active_cfg.repeat_delay + active_cfg.repeat_rate) / 4 + 2;
    end else if (dir == DIR_CENTER) begin
      step_max = active_cfg.reboot_hold / 3 + 2;
      run_len = $urandom_range(1, 6);
    end else begin
      step_max = 60;
    end
    for (int k = 0; k < run_len; k++) begin
      if ($urandom_range(99) < 3) begin
        clock_ms = $urandom();
      end else begin
        clock_ms = clock_ms + $urandom_range(0, step_max);
      end
      send_sample(dir, clock_ms, $urandom_range(99) < 30);
      samples_sent++;
    end
  endtask

  task automatic play_phase(input int quota);
    while (samples_sent < quota) play_hold();
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    direction_i <= DIR_NONE;
    now_ms_i <= '0;
    display_busy_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_REPEAT_DELAY;
    cfg_data_i <= '0;
    steady = 1'b0;
    clock_ms = '0;
    active_cfg = '{repeat_delay: RepeatDelayReset, repeat_rate: RepeatRateReset,
                   reboot_hold: RebootHoldReset};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(DIR_NONE, 32'd0, 1'b0);
    send_sample(DIR_UP, 32'd5, 1'b0);
    send_sample(DIR_UP, 32'd405, 1'b0);
    send_sample(DIR_UP, 32'd406, 1'b0);
    send_sample(DIR_UP, 32'd526, 1'b0);
    send_sample(DIR_UP, 32'd527, 1'b0);
    send_sample(DIR_DOWN, 32'd600, 1'b1);
    send_sample(DIR_DOWN, 32'd610, 1'b0);
    send_sample(DIR_LEFT, 32'd620, 1'b1);
    send_sample(DIR_RIGHT, 32'd630, 1'b1);
    send_sample(DIR_NONE, 32'd640, 1'b0);
    send_sample(DirInvalidLo, 32'd650, 1'b0);
    send_sample(DirInvalidHi, 32'd660, 1'b0);
    send_sample(DIR_CENTER, 32'd1000, 1'b0);
    send_sample(DIR_CENTER, 32'd5000, 1'b0);
    send_sample(DIR_CENTER, 32'd10999, 1'b0);
    send_sample(DIR_CENTER, 32'd11000, 1'b0);
    send_sample(DIR_CENTER, 32'd0, 1'b0);
    send_sample(DIR_CENTER, 32'd5, 1'b0);
    send_sample(DIR_CENTER, 32'd10004, 1'b0);
    send_sample(DIR_CENTER, 32'd10005, 1'b0);
    send_sample(DIR_DOWN, 32'hFFFF_FFF0, 1'b0);
    send_sample(DIR_DOWN, 32'h0000_0180, 1'b0);
    send_sample(DIR_DOWN, 32'h0000_0181, 1'b1);
    send_sample(DIR_NONE, 32'hFFFF_FFFF, 1'b0);

    drain_pacer();
    load_config('0, '0, '0);
    send_sample(DIR_CENTER, 32'd7, 1'b0);
    send_sample(DIR_CENTER, 32'd7, 1'b0);
    send_sample(DIR_UP, 32'd10, 1'b0);
    send_sample(DIR_UP, 32'd10, 1'b0);
    send_sample(DIR_UP, 32'd11, 1'b0);

    steady = 1'b1;
    play_phase(300);
    steady = 1'b0;
    play_phase(SamplesPerPhase);

    drain_pacer();
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    play_phase(2 * SamplesPerPhase);

    drain_pacer();
    load_config(CfgW'($urandom_range(1000)), CfgW'($urandom_range(300)),
                CfgW'($urandom_range(1, 20000)));
    play_phase(3 * SamplesPerPhase);

    drain_pacer();
    load_config(RepeatDelayReset, RepeatRateReset, RebootHoldReset);
    play_phase(4 * SamplesPerPhase);

    drain_pacer();
    if (mismatches == 0 && words_in_flight == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
